[src/ifdf_pkg.sv]
// ----------------------------------------------------------------------------
// ifdf_pkg
// Shared types, constants and codes for the decimal integer field formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package ifdf_pkg;

   // Field widths of the request and response items
   localparam int CMD_W       = 1;
   localparam int VALUE_W     = 64;
   localparam int SIGN_SEL_W  = 2;
   localparam int FIELD_W     = 6;
   localparam int CHAR_W      = 8;

   localparam int MAX_WIDTH_DEFAULT = 63;

   // Request tdata layout, lowest bit first
   localparam int REQ_VALUE_LSB = 0;
   localparam int REQ_SMODE_LSB = REQ_VALUE_LSB + VALUE_W;
   localparam int REQ_WIDTH_LSB = REQ_SMODE_LSB + SIGN_SEL_W;
   localparam int REQ_LJUST_BIT = REQ_WIDTH_LSB + FIELD_W;
   localparam int REQ_ZPAD_BIT  = REQ_LJUST_BIT + 1;
   localparam int REQ_USED_W    = REQ_ZPAD_BIT + 1;
   localparam int REQ_TDATA_W   = ((REQ_USED_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W   = CHAR_W;

   // Binary to BCD conversion
   localparam int NUM_DIGITS    = 20;
   localparam int DIGIT_W       = 4;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
   localparam int STEP_CNT_W    = $clog2(CONV_STEPS);
   localparam int TLEN_W        = $clog2(NUM_DIGITS + 1);

   // Character codes
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   // Conversion kinds
   localparam logic [CMD_W-1:0] CMD_INT  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_CHAR = 1'b1;

   // Sign modes
   localparam logic [SIGN_SEL_W-1:0] SIGN_NONE  = 2'd0;
   localparam logic [SIGN_SEL_W-1:0] SIGN_PLUS  = 2'd1;
   localparam logic [SIGN_SEL_W-1:0] SIGN_SPACE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_PLAN,
      ST_EMIT
   } fmt_state_type;

   typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_type;

   // Segment boundaries of one field, as running character positions
   typedef struct packed {
      logic [FIELD_W-1:0] lead_end;
      logic [FIELD_W-1:0] sign_end;
      logic [FIELD_W-1:0] zero_end;
      logic [FIELD_W-1:0] text_end;
      logic [FIELD_W-1:0] total;
      logic [CHAR_W-1:0]  sign_char;
      logic               is_char;
      logic [CHAR_W-1:0]  char_val;
   } plan_type;

   typedef struct packed {
      logic busy;
      logic done;
   } emit_status_type;

endpackage : ifdf_pkg

`default_nettype wire

[src/ifdf_bcd_conv.sv]
// ----------------------------------------------------------------------------
// ifdf_bcd_conv
// Iterative binary to BCD converter: one shift/add-3 unit applied four bit
// positions per cycle until all 64 input bits are shifted in.
// ----------------------------------------------------------------------------
`default_nettype none

module ifdf_bcd_conv (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   input  wire  [ifdf_pkg::VALUE_W-1:0]    magnitude,
   output logic                            done,
   output ifdf_pkg::bcd_type               bcd
);
   import ifdf_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_CNT_W-1:0] step_ff, step_in;
   logic [VALUE_W-1:0]    bin_ff, bin_in;
   bcd_type               bcd_ff, bcd_in;

   logic [VALUE_W-1:0]    bin_next;
   bcd_type               bcd_next;

   // Shift/add-3 unit
   always_comb begin
      logic [VALUE_W-1:0] b;
      bcd_type            d;
      b = bin_ff;
      d = bcd_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int k = 0; k < NUM_DIGITS; k++) begin
            if (d[k] >= DIGIT_W'(5)) begin
               d[k] = d[k] + DIGIT_W'(3);
            end
         end
         {d, b} = {d, b} << 1;
      end
      bin_next = b;
      bcd_next = d;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         bin_in  = magnitude;
         bcd_in  = '0;
      end else if (busy_ff) begin
         bin_in  = bin_next;
         bcd_in  = bcd_next;
         step_in = step_ff + STEP_CNT_W'(1);
         if (step_ff == STEP_CNT_W'(CONV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

`ifndef NO_ASSERTIONS
   // a new conversion must never cut into a running one
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("conversion restarted while busy");
`endif

endmodule : ifdf_bcd_conv

`default_nettype wire

[src/ifdf_field_emit.sv]
// ----------------------------------------------------------------------------
// ifdf_field_emit
// Walks the character positions of one field and drives the response
// channel through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ifdf_field_emit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   input  wire  ifdf_pkg::plan_type           plan,
   input  wire  ifdf_pkg::bcd_type            bcd,
   output ifdf_pkg::emit_status_type          status,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [ifdf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // [7:0] out_char
   output logic                               rsp_tlast
);
   import ifdf_pkg::*;

   logic               busy_ff, busy_in;
   logic [FIELD_W-1:0] pos_ff, pos_in;
   plan_type           plan_ff, plan_in;
   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;

   logic               load;
   logic               is_last;
   logic [FIELD_W-1:0] digit_idx;
   logic [DIGIT_W-1:0] digit;
   logic [CHAR_W-1:0]  cur_char;

   assign load    = busy_ff && (!valid_ff || rsp_tready);
   assign is_last = (pos_ff == plan_ff.total - FIELD_W'(1));

   // digits are stored least significant first
   assign digit_idx = plan_ff.text_end - FIELD_W'(1) - pos_ff;

   always_comb begin
      digit = '0;
      for (int k = 0; k < NUM_DIGITS; k++) begin
         if (digit_idx == FIELD_W'(k)) begin
            digit = bcd[k];
         end
      end
   end

   always_comb begin
      if (pos_ff < plan_ff.lead_end) begin
         cur_char = CH_SPACE;
      end else if (pos_ff < plan_ff.sign_end) begin
         cur_char = plan_ff.sign_char;
      end else if (pos_ff < plan_ff.zero_end) begin
         cur_char = CH_ZERO;
      end else if (pos_ff < plan_ff.text_end) begin
         cur_char = plan_ff.is_char ? plan_ff.char_val
                                    : (CH_ZERO | {{(CHAR_W-DIGIT_W){1'b0}}, digit});
      end else begin
         cur_char = CH_SPACE;
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      plan_in  = plan_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (start) begin
         busy_in = 1'b1;
         pos_in  = '0;
         plan_in = plan;
      end else if (load) begin
         valid_in = 1'b1;
         char_in  = cur_char;
         last_in  = is_last;
         pos_in   = pos_ff + FIELD_W'(1);
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
      plan_ff <= plan_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign status.busy = busy_ff;
   assign status.done = load && is_last;
   assign rsp_tvalid  = valid_ff;
   assign rsp_tdata   = char_ff;
   assign rsp_tlast   = last_ff;

`ifndef NO_ASSERTIONS
   a_pos_in_field: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff < plan_ff.total))
      else $error("character position ran past end of field");
`endif

endmodule : ifdf_field_emit

`default_nettype wire

[src/integer_decimal_field_formatter.sv]
// ----------------------------------------------------------------------------
// integer_decimal_field_formatter
// Formats one decoded %d or %c conversion into a padded ASCII field, one
// character per response transfer, the final character flagged by tlast.
// ----------------------------------------------------------------------------
// One request is taken at a time. A %d request is accepted, run through the
// binary to BCD unit (four bit positions per cycle) until its completion
// flag, laid out as a field in the plan state, then emitted one character
// per response transfer, each of which the response side can stall; a %c
// request skips the BCD unit. The next request is accepted once the final
// character sits in the output register.
`default_nettype none

module integer_decimal_field_formatter #(
   parameter int MAX_WIDTH = ifdf_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // [63:0] value, [65:64] sign_sel, [71:66] width, [72] left_justify,
   // [73] zero_pad, [79:74] zero
   input  wire  [ifdf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire  [ifdf_pkg::CMD_W-1:0]         req_tuser,   // [0] command
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [ifdf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // [7:0] out_char
   output logic                               rsp_tlast
);
   import ifdf_pkg::*;

   localparam int FieldMax  = (1 << FIELD_W) - 1;
   localparam int ClipWidth = (MAX_WIDTH < FieldMax) ? MAX_WIDTH : FieldMax;

   fmt_state_type state_ff, state_in;

   logic                   cmd_char_ff;
   logic                   neg_ff;
   logic                   nonzero_ff;
   logic [SIGN_SEL_W-1:0]  smode_ff;
   logic [FIELD_W-1:0]     fw_ff;
   logic                   ljust_ff;
   logic                   zpad_ff;
   logic [CHAR_W-1:0]      chr_ff;

   logic                   accept;
   logic [VALUE_W-1:0]     req_value;
   logic [FIELD_W-1:0]     req_width;
   logic [FIELD_W-1:0]     fw_clip;
   logic [VALUE_W-1:0]     magnitude;
   logic                   conv_start;
   logic                   conv_done;
   logic                   emit_start;
   bcd_type                bcd;
   emit_status_type        emit_stat;
   plan_type               plan;

   assign accept    = req_tvalid && req_tready;
   assign req_value = req_tdata[REQ_VALUE_LSB +: VALUE_W];
   assign req_width = req_tdata[REQ_WIDTH_LSB +: FIELD_W];
   assign fw_clip   = (req_width > FIELD_W'(ClipWidth)) ? FIELD_W'(ClipWidth) : req_width;
   // most negative value negates to itself, which reads right as unsigned
   assign magnitude = req_value[VALUE_W-1] ? (~req_value + VALUE_W'(1)) : req_value;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_tuser == CMD_CHAR) ? ST_PLAN : ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_stat.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      conv_start = 1'b0;
      emit_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            conv_start = accept && (req_tuser == CMD_INT);
         end
         ST_PLAN: begin
            emit_start = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (accept) begin
         cmd_char_ff <= (req_tuser == CMD_CHAR);
         neg_ff      <= (req_tuser == CMD_INT) && req_value[VALUE_W-1];
         nonzero_ff  <= (req_tuser == CMD_INT) && (req_value != '0);
         smode_ff    <= req_tdata[REQ_SMODE_LSB +: SIGN_SEL_W];
         fw_ff       <= fw_clip;
         ljust_ff    <= req_tdata[REQ_LJUST_BIT];
         zpad_ff     <= req_tdata[REQ_ZPAD_BIT];
         chr_ff      <= req_value[CHAR_W-1:0];
      end
   end

   // field layout
   always_comb begin
      logic [TLEN_W-1:0]  nd;
      logic               has_sign;
      logic [FIELD_W-1:0] text_len;
      logic [FIELD_W-1:0] pad;
      logic [FIELD_W-1:0] lead_sp;
      logic [FIELD_W-1:0] lead_zero;
      logic [FIELD_W-1:0] trail_sp;
      nd = TLEN_W'(1);
      for (int k = 1; k < NUM_DIGITS; k++) begin
         if (bcd[k] != '0) begin
            nd = TLEN_W'(k + 1);
         end
      end
      has_sign = neg_ff ||
                 (nonzero_ff && ((smode_ff == SIGN_PLUS) || (smode_ff == SIGN_SPACE)));
      text_len = cmd_char_ff ? FIELD_W'(1) : {{(FIELD_W-TLEN_W){1'b0}}, nd};
      text_len = text_len + {{(FIELD_W-1){1'b0}}, has_sign};
      pad      = (fw_ff > text_len) ? (fw_ff - text_len) : '0;
      lead_sp   = (!ljust_ff && !zpad_ff) ? pad : '0;
      lead_zero = (!ljust_ff &&  zpad_ff) ? pad : '0;
      trail_sp  = ljust_ff ? pad : '0;

      plan.lead_end  = lead_sp;
      plan.sign_end  = lead_sp + {{(FIELD_W-1){1'b0}}, has_sign};
      plan.zero_end  = plan.sign_end + lead_zero;
      plan.text_end  = plan.zero_end + (text_len - {{(FIELD_W-1){1'b0}}, has_sign});
      plan.total     = plan.text_end + trail_sp;
      plan.sign_char = neg_ff ? CH_MINUS : ((smode_ff == SIGN_PLUS) ? CH_PLUS : CH_SPACE);
      plan.is_char   = cmd_char_ff;
      plan.char_val  = chr_ff;
   end

   ifdf_bcd_conv u_bcd_conv (
      .clock     (clock),
      .reset     (reset),
      .start     (conv_start),
      .magnitude (magnitude),
      .done      (conv_done),
      .bcd       (bcd)
   );

   ifdf_field_emit u_field_emit (
      .clock      (clock),
      .reset      (reset),
      .start      (emit_start),
      .plan       (plan),
      .bcd        (bcd),
      .status     (emit_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   a_plan_fills_width: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PLAN) |-> ((plan.total >= fw_ff) && (plan.total != '0)))
      else $error("field layout shorter than requested width");

   a_idle_emitter_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !emit_stat.busy)
      else $error("idle while a field is still being emitted");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request taken while previous one in progress");
`endif

endmodule : integer_decimal_field_formatter

`default_nettype wire
